@@ hw/rtl/psg_pkg.sv @@
// Shared types, register map, constants and lookup functions of the sound generator.
package psg_pkg;

   localparam int TONE_COUNT_BITS_DEFAULT = 16;

   typedef enum logic [1:0] {
      MODE_SELECT = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_READ   = 2'd2,
      MODE_TICK   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  reg_addr;
      logic [7:0]  data;
      logic [7:0]  delta;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [5:0]  level_a;
      logic [5:0]  level_b;
      logic [5:0]  level_c;
   } rsp_payload_type;

   // Register settings that the tone, noise and envelope logic works from.
   typedef struct packed {
      logic [2:0][11:0] tone_period;
      logic [4:0]       noise_period;
      logic [7:0]       mixer;
      logic [2:0][4:0]  volume;
      logic [15:0]      env_period;
      logic [3:0]       env_shape;
   } psg_cfg_type;

   localparam logic [7:0] REG_TONE_A_LO  = 8'd0;
   localparam logic [7:0] REG_TONE_A_HI  = 8'd1;
   localparam logic [7:0] REG_TONE_B_LO  = 8'd2;
   localparam logic [7:0] REG_TONE_B_HI  = 8'd3;
   localparam logic [7:0] REG_TONE_C_LO  = 8'd4;
   localparam logic [7:0] REG_TONE_C_HI  = 8'd5;
   localparam logic [7:0] REG_NOISE      = 8'd6;
   localparam logic [7:0] REG_MIXER      = 8'd7;
   localparam logic [7:0] REG_VOL_A      = 8'd8;
   localparam logic [7:0] REG_VOL_B      = 8'd9;
   localparam logic [7:0] REG_VOL_C      = 8'd10;
   localparam logic [7:0] REG_ENV_LO     = 8'd11;
   localparam logic [7:0] REG_ENV_HI     = 8'd12;
   localparam logic [7:0] REG_ENV_SHAPE  = 8'd13;
   localparam logic [7:0] REG_PORT_A     = 8'd14;
   localparam logic [7:0] REG_PORT_B     = 8'd15;

   localparam logic [7:0] NOISE_MASK  = 8'h1f;
   localparam logic [7:0] NIBBLE_MASK = 8'h0f;
   localparam logic [7:0] VOLUME_MASK = 8'h1f;

   localparam logic [31:0] LFSR_TAPS  = 32'hea000001;
   localparam logic [31:0] LFSR_TOP   = 32'h80000000;
   localparam logic [31:0] LFSR_RESET = 32'h00000001;

   // Envelope shapes with the top bit set; the others behave as a single ramp.
   localparam logic [3:0] SHAPE_SAW_DOWN    = 4'd8;
   localparam logic [3:0] SHAPE_DECAY_ONCE  = 4'd9;
   localparam logic [3:0] SHAPE_TRI_DOWN    = 4'd10;
   localparam logic [3:0] SHAPE_DECAY_HOLD  = 4'd11;
   localparam logic [3:0] SHAPE_SAW_UP      = 4'd12;
   localparam logic [3:0] SHAPE_ATTACK_HOLD = 4'd13;
   localparam logic [3:0] SHAPE_TRI_UP      = 4'd14;

   localparam logic [5:0] AMP_TABLE [16] = '{
      6'd0, 6'd2, 6'd4, 6'd5, 6'd7, 6'd8, 6'd9, 6'd11,
      6'd12, 6'd14, 6'd16, 6'd19, 6'd23, 6'd28, 6'd34, 6'd40
   };

   function automatic logic [5:0] amp_lookup(input logic [3:0] idx);
      return AMP_TABLE[idx];
   endfunction

   function automatic logic [5:0] shape_level(input logic [3:0] shape,
                                              input logic [3:0] step,
                                              input logic       first_done,
                                              input logic       direction);
      logic [5:0] up;
      logic [5:0] down;
      logic [5:0] level;
      up   = amp_lookup(step);
      down = amp_lookup(4'hf - step);
      if (!shape[3]) begin
         level = first_done ? amp_lookup(4'h0) : (shape[2] ? up : down);
      end else begin
         case (shape)
            SHAPE_SAW_DOWN:    level = down;
            SHAPE_DECAY_ONCE:  level = first_done ? amp_lookup(4'h0) : down;
            SHAPE_TRI_DOWN:    level = direction ? down : up;
            SHAPE_DECAY_HOLD:  level = first_done ? amp_lookup(4'hf) : down;
            SHAPE_SAW_UP:      level = up;
            SHAPE_ATTACK_HOLD: level = first_done ? amp_lookup(4'hf) : up;
            SHAPE_TRI_UP:      level = direction ? up : down;
            default:           level = first_done ? amp_lookup(4'h0) : up;
         endcase
      end
      return level;
   endfunction

endpackage

@@ hw/rtl/three_voice_psg_with_envelope_top.sv @@
// An accepted item reaches rsp through the input stage, the state update and result register.
// Throughput: one item per cycle while rsp is not stalled.
// The input is stalled only while the input stage is full and the result register is held.
// Reset is synchronous and active high; it clears the valid flags and state, not the payload registers.
// Top level of the three-voice sound generator with envelope.
module three_voice_psg_with_envelope_top
   import psg_pkg::*;
#(
   parameter int TONE_COUNT_BITS = TONE_COUNT_BITS_DEFAULT
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            stg_valid_ff, stg_valid_in;
   req_payload_type stg_payload_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            out_free;
   logic            advance;
   logic            req_take;
   logic            tick_en;
   psg_cfg_type     cfg;
   logic [7:0]      reg_rdata;
   logic            shape_write;
   logic [2:0]      chan;
   logic [5:0]      env_level;
   logic [2:0][5:0] amp;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = stg_valid_ff && out_free;
   assign req_stall    = stg_valid_ff && !out_free;
   assign req_take     = req_valid && !req_stall;
   assign tick_en      = advance && (stg_payload_ff.mode == MODE_TICK);
   assign stg_valid_in = req_take || (stg_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   psg_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .op_en       (advance),
      .mode        (stg_payload_ff.mode),
      .reg_addr    (stg_payload_ff.reg_addr),
      .data        (stg_payload_ff.data),
      .cfg         (cfg),
      .read_data   (reg_rdata),
      .shape_write (shape_write)
   );

   psg_tone #(
      .TONE_COUNT_BITS (TONE_COUNT_BITS)
   ) u_tone (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .delta   (stg_payload_ff.delta),
      .cfg     (cfg),
      .chan    (chan)
   );

   psg_env u_env (
      .clock       (clock),
      .reset       (reset),
      .tick_en     (tick_en),
      .shape_write (shape_write),
      .delta       (stg_payload_ff.delta),
      .cfg         (cfg),
      .level       (env_level)
   );

   // Volume bit 4 hands the channel over to the envelope level.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!chan[i]) begin
            amp[i] = 6'd0;
         end else if (cfg.volume[i][4]) begin
            amp[i] = env_level;
         end else begin
            amp[i] = amp_lookup(cfg.volume[i][3:0]);
         end
      end
   end

   always_comb begin
      rsp_payload_in = '0;
      if (stg_payload_ff.mode == MODE_READ) begin
         rsp_payload_in.read_data = reg_rdata;
      end
      if (stg_payload_ff.mode == MODE_TICK) begin
         rsp_payload_in.level_a = amp[0];
         rsp_payload_in.level_b = amp[1];
         rsp_payload_in.level_c = amp[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_payload_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ hw/rtl/psg_regs.sv @@
// Register file of the sound generator: register select, masked writes and reads.
module psg_regs
   import psg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        op_en,
   input  mode_type    mode,
   input  logic [7:0]  reg_addr,
   input  logic [7:0]  data,
   output psg_cfg_type cfg,
   output logic [7:0]  read_data,
   output logic        shape_write
);

   // All settings clear at reset except the mixer, which starts with every source off.
   localparam psg_cfg_type CFG_RESET = '{
      tone_period:  '0,
      noise_period: '0,
      mixer:        8'hff,
      volume:       '0,
      env_period:   '0,
      env_shape:    '0
   };

   logic [7:0]  sel_ff, sel_in;
   psg_cfg_type cfg_ff, cfg_in;
   logic [7:0]  port_a_ff, port_a_in;
   logic [7:0]  port_b_ff, port_b_in;
   logic        we;
   logic [1:0]  tone_idx;

   assign we       = op_en && (mode == MODE_WRITE);
   assign tone_idx = sel_ff[2:1];

   always_comb begin
      sel_in      = sel_ff;
      cfg_in      = cfg_ff;
      port_a_in   = port_a_ff;
      port_b_in   = port_b_ff;
      shape_write = 1'b0;
      if (op_en && (mode == MODE_SELECT)) begin
         sel_in = reg_addr;
      end
      if (we) begin
         case (sel_ff)
            REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO: begin
               cfg_in.tone_period[tone_idx][7:0] = data;
            end
            REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: begin
               cfg_in.tone_period[tone_idx][11:8] = data[3:0];
            end
            REG_NOISE:  cfg_in.noise_period = data[4:0];
            REG_MIXER:  cfg_in.mixer = data;
            REG_VOL_A:  cfg_in.volume[0] = data[4:0];
            REG_VOL_B:  cfg_in.volume[1] = data[4:0];
            REG_VOL_C:  cfg_in.volume[2] = data[4:0];
            REG_ENV_LO: cfg_in.env_period[7:0] = data;
            REG_ENV_HI: cfg_in.env_period[15:8] = data;
            REG_ENV_SHAPE: begin
               cfg_in.env_shape = data[3:0];
               shape_write      = 1'b1;
            end
            REG_PORT_A: port_a_in = data;
            REG_PORT_B: port_b_in = data;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel_ff)
         REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO:
            read_data = cfg_ff.tone_period[tone_idx][7:0];
         REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI:
            read_data = {4'h0, cfg_ff.tone_period[tone_idx][11:8]} & NIBBLE_MASK;
         REG_NOISE:     read_data = {3'h0, cfg_ff.noise_period} & NOISE_MASK;
         REG_MIXER:     read_data = cfg_ff.mixer;
         REG_VOL_A:     read_data = {3'h0, cfg_ff.volume[0]} & VOLUME_MASK;
         REG_VOL_B:     read_data = {3'h0, cfg_ff.volume[1]} & VOLUME_MASK;
         REG_VOL_C:     read_data = {3'h0, cfg_ff.volume[2]} & VOLUME_MASK;
         REG_ENV_LO:    read_data = cfg_ff.env_period[7:0];
         REG_ENV_HI:    read_data = cfg_ff.env_period[15:8];
         REG_ENV_SHAPE: read_data = {4'h0, cfg_ff.env_shape} & NIBBLE_MASK;
         REG_PORT_A:    read_data = port_a_ff;
         REG_PORT_B:    read_data = port_b_ff;
         default:       read_data = 8'h00;
      endcase
   end

   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff    <= 8'h00;
         cfg_ff    <= CFG_RESET;
         port_a_ff <= 8'hff;
         port_b_ff <= 8'h00;
      end else begin
         sel_ff    <= sel_in;
         cfg_ff    <= cfg_in;
         port_a_ff <= port_a_in;
         port_b_ff <= port_b_in;
      end
   end

endmodule

@@ hw/rtl/psg_tone.sv @@
// Tone counters, noise counter and noise LFSR; gives the gate bit of each channel.
module psg_tone
   import psg_pkg::*;
#(
   parameter int TONE_COUNT_BITS = TONE_COUNT_BITS_DEFAULT
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             tick_en,
   input  logic [7:0]       delta,
   input  psg_cfg_type      cfg,
   output logic [2:0]       chan
);

   localparam int CW = TONE_COUNT_BITS;

   logic [CW-1:0] count_ff [3];
   logic [CW-1:0] count_in [3];
   logic [2:0]    bit_ff, bit_in;
   logic [8:0]    ncount_ff, ncount_in;
   logic          nbit_ff, nbit_in;
   logic [31:0]   lfsr_ff, lfsr_in;

   logic [2:0]    tone_en;
   logic [2:0]    noise_en;
   logic          noise_any;
   logic [CW:0]   tsum [3];
   logic [CW-1:0] tsat [3];
   logic [9:0]    nsum;
   logic [8:0]    nsat;
   logic [2:0]    gate;

   assign tone_en   = ~cfg.mixer[2:0];
   assign noise_en  = ~cfg.mixer[5:3];
   assign noise_any = |noise_en;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tsum[i]     = {1'b0, count_ff[i]} + {{(CW-7){1'b0}}, delta};
         tsat[i]     = tsum[i][CW] ? {CW{1'b1}} : tsum[i][CW-1:0];
         gate[i]     = bit_ff[i];
         count_in[i] = count_ff[i];
         bit_in[i]   = bit_ff[i];
         if (tick_en) begin
            if (tone_en[i]) begin
               count_in[i] = tsat[i];
               // The period must also cover the step, or the bit never toggles.
               if ((tsat[i] >= {{(CW-12){1'b0}}, cfg.tone_period[i]}) &&
                   (cfg.tone_period[i] >= {4'h0, delta})) begin
                  bit_in[i]   = ~bit_ff[i];
                  count_in[i] = '0;
               end
            end else begin
               gate[i]     = 1'b1;
               count_in[i] = '0;
            end
         end
      end
   end

   always_comb begin
      nsum      = {1'b0, ncount_ff} + {2'b00, delta};
      nsat      = nsum[9] ? 9'h1ff : nsum[8:0];
      ncount_in = ncount_ff;
      nbit_in   = nbit_ff;
      lfsr_in   = lfsr_ff;
      chan      = gate;
      if (tick_en && noise_any) begin
         ncount_in = nsat;
         if (nsat >= {3'b000, cfg.noise_period, 1'b0}) begin
            nbit_in   = lfsr_ff[0];
            ncount_in = '0;
            lfsr_in   = lfsr_ff[0] ? (((lfsr_ff ^ LFSR_TAPS) >> 1) | LFSR_TOP)
                                   : (lfsr_ff >> 1);
         end
         if (!nbit_in) begin
            chan = gate & ~noise_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            count_ff[i] <= '0;
         end
         bit_ff    <= '0;
         ncount_ff <= '0;
         nbit_ff   <= 1'b0;
         lfsr_ff   <= LFSR_RESET;
      end else begin
         for (int i = 0; i < 3; i++) begin
            count_ff[i] <= count_in[i];
         end
         bit_ff    <= bit_in;
         ncount_ff <= ncount_in;
         nbit_ff   <= nbit_in;
         lfsr_ff   <= lfsr_in;
      end
   end

endmodule

@@ hw/rtl/psg_env.sv @@
// Envelope generator: accumulator, step counter and shape-dependent level.
module psg_env
   import psg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        tick_en,
   input  logic        shape_write,
   input  logic [7:0]  delta,
   input  psg_cfg_type cfg,
   output logic [5:0]  level
);

   logic [31:0] accum_ff, accum_in;
   logic [3:0]  step_ff, step_in;
   logic        first_ff, first_in;
   logic        dir_ff, dir_in;
   logic [5:0]  level_ff, level_in;
   logic        restart_ff, restart_in;

   logic [32:0] sum;
   logic [31:0] limit;

   assign sum   = {1'b0, accum_ff} + {25'h0, delta};
   assign limit = {15'h0, cfg.env_period, 1'b0};

   always_comb begin
      accum_in   = accum_ff;
      step_in    = step_ff;
      first_in   = first_ff;
      dir_in     = dir_ff;
      level_in   = level_ff;
      restart_in = restart_ff;
      if (shape_write) begin
         restart_in = 1'b1;
      end
      if (tick_en) begin
         accum_in   = sum[32] ? 32'hffffffff : sum[31:0];
         restart_in = 1'b0;
         if (restart_ff) begin
            accum_in = '0;
            step_in  = '0;
            first_in = 1'b0;
            dir_in   = 1'b1;
         end
         if (accum_in >= limit) begin
            accum_in = accum_in - limit;
            step_in  = step_in + 4'd1;
            // Wrapping to step zero ends a full ramp.
            if (step_in == 4'd0) begin
               first_in = 1'b1;
               dir_in   = ~dir_in;
            end
            level_in = shape_level(cfg.env_shape, step_in, first_in, dir_in);
         end
      end
   end

   assign level = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff   <= '0;
         step_ff    <= '0;
         first_ff   <= 1'b0;
         dir_ff     <= 1'b1;
         level_ff   <= '0;
         restart_ff <= 1'b0;
      end else begin
         accum_ff   <= accum_in;
         step_ff    <= step_in;
         first_ff   <= first_in;
         dir_ff     <= dir_in;
         level_ff   <= level_in;
         restart_ff <= restart_in;
      end
   end

endmodule

@@ hw/rtl/psg_checker.sv @@
// Port-level checker for the sound generator top level, with its bind statement.
module psg_checker
   import psg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload
);

   // A held result keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("held result changed or dropped");

   // A result that carries read data comes from a read, so all levels are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.read_data != 8'h00) |->
         (rsp_payload.level_a == 6'd0) && (rsp_payload.level_b == 6'd0) &&
         (rsp_payload.level_c == 6'd0))
      else $error("read result with nonzero level");

   // Levels never exceed the top of the amplitude table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.level_a <= 6'd40) && (rsp_payload.level_b <= 6'd40) &&
                    (rsp_payload.level_c <= 6'd40))
      else $error("level out of range");

   // An accepted item reaches the output through the input stage if the output does not stall.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted item did not reach the output");

endmodule

bind three_voice_psg_with_envelope_top psg_checker u_psg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

@@ bench/three_voice_psg_with_envelope_top_test.sv @@
// Self-checking bench for the sound generator: bus and tick items checked against a predictor.
`timescale 1ns / 1ps
module three_voice_psg_with_envelope_top_test;
   import psg_pkg::*;

   localparam int COUNT_BITS       = TONE_COUNT_BITS_DEFAULT;
   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
   localparam int NOISE_COUNT_MAX  = 511;
   localparam int HOLD_CYCLES      = 60;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int RANDOM_PER_PHASE = 80;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   // Predicted register file and generator state.
   logic [7:0]      selected_reg;
   logic [11:0]     tone_period [3];
   logic [4:0]      noise_period;
   logic [7:0]      mixer;
   logic [4:0]      volume [3];
   logic [15:0]     env_period;
   logic [3:0]      env_shape;
   logic [7:0]      port_a;
   logic [7:0]      port_b;
   logic            env_restart;
   longint unsigned tone_count [3];
   logic            tone_bit [3];
   int unsigned     noise_count;
   logic            noise_gate;
   logic [31:0]     lfsr;
   logic [31:0]     env_accum;
   logic [3:0]      env_step;
   logic            env_first_done;
   logic            env_direction;
   logic [5:0]      env_level;

   req_payload_type pending_accesses [$];
   rsp_payload_type expected_outputs [$];
   rsp_payload_type oldest_output;

   int items_queued   = 0;
   int items_accepted = 0;
   int ticks_accepted = 0;
   int results_checked = 0;
   int fail_count     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   three_voice_psg_with_envelope_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic logic [5:0] envelope_level(input logic [3:0] shape, input logic [3:0] step,
                                                 input logic done, input logic dir);
      logic [5:0] rise;
      logic [5:0] fall;
      logic [5:0] lvl;
      rise = AMP_TABLE[step];
      fall = AMP_TABLE[4'hf - step];
      case (shape)
         SHAPE_SAW_DOWN:    lvl = fall;
         SHAPE_SAW_UP:      lvl = rise;
         SHAPE_TRI_DOWN:    lvl = dir ? fall : rise;
         SHAPE_TRI_UP:      lvl = dir ? rise : fall;
         SHAPE_DECAY_HOLD:  lvl = done ? AMP_TABLE[15] : fall;
         SHAPE_ATTACK_HOLD: lvl = done ? AMP_TABLE[15] : rise;
         SHAPE_DECAY_ONCE:  lvl = done ? AMP_TABLE[0] : fall;
         // The remaining shapes ramp once, down or up by bit 2, and then stay silent.
         default:           lvl = done ? AMP_TABLE[0] : (shape[2] ? rise : fall);
      endcase
      return lvl;
   endfunction

   // Advances the predicted state by one item and returns the result it gives.
   function automatic rsp_payload_type psg_next_output(input req_payload_type item);
      rsp_payload_type res;
      logic [2:0]      audible;
      logic [5:0]      lvl [3];
      longint unsigned sum;
      logic [31:0]     env_limit;
      int              i;
      res = '0;
      case (item.mode)
         MODE_SELECT: selected_reg = item.reg_addr;
         MODE_WRITE: begin
            case (selected_reg)
               REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO:
                  tone_period[selected_reg[2:1]][7:0] = item.data;
               REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI:
                  tone_period[selected_reg[2:1]][11:8] = item.data[3:0];
               REG_NOISE:  noise_period = item.data[4:0];
               REG_MIXER:  mixer = item.data;
               REG_VOL_A, REG_VOL_B, REG_VOL_C:
                  volume[selected_reg - REG_VOL_A] = item.data[4:0];
               REG_ENV_LO: env_period[7:0] = item.data;
               REG_ENV_HI: env_period[15:8] = item.data;
               REG_ENV_SHAPE: begin
                  env_shape   = item.data[3:0];
                  env_restart = 1'b1;
               end
               REG_PORT_A: port_a = item.data;
               REG_PORT_B: port_b = item.data;
               default: ;
            endcase
         end
         MODE_READ: begin
            case (selected_reg)
               REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO:
                  res.read_data = tone_period[selected_reg[2:1]][7:0];
               REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI:
                  res.read_data = {4'd0, tone_period[selected_reg[2:1]][11:8]};
               REG_NOISE:     res.read_data = {3'd0, noise_period};
               REG_MIXER:     res.read_data = mixer;
               REG_VOL_A, REG_VOL_B, REG_VOL_C:
                  res.read_data = {3'd0, volume[selected_reg - REG_VOL_A]};
               REG_ENV_LO:    res.read_data = env_period[7:0];
               REG_ENV_HI:    res.read_data = env_period[15:8];
               REG_ENV_SHAPE: res.read_data = {4'd0, env_shape};
               REG_PORT_A:    res.read_data = port_a;
               REG_PORT_B:    res.read_data = port_b;
               default:       res.read_data = '0;
            endcase
         end
         default: begin
            for (i = 0; i < 3; i++) begin
               // The channel sounds the square bit as it was before any toggle.
               audible[i] = tone_bit[i];
               if (!mixer[i]) begin
                  sum = tone_count[i] + item.delta;
                  if (sum > COUNT_MAX) sum = COUNT_MAX;
                  tone_count[i] = sum;
                  if (sum >= tone_period[i] && tone_period[i] >= item.delta) begin
                     tone_bit[i]   = ~tone_bit[i];
                     tone_count[i] = 0;
                  end
               end else begin
                  audible[i]    = 1'b1;
                  tone_count[i] = 0;
               end
            end
            if (mixer[5:3] != 3'b111) begin
               sum = noise_count + item.delta;
               if (sum > NOISE_COUNT_MAX) sum = NOISE_COUNT_MAX;
               noise_count = 32'(sum);
               if (noise_count >= {noise_period, 1'b0}) begin
                  noise_gate  = lfsr[0];
                  lfsr        = lfsr[0] ? (((lfsr ^ LFSR_TAPS) >> 1) | LFSR_TOP) : (lfsr >> 1);
                  noise_count = 0;
               end
               // A low noise bit silences every channel that has noise enabled.
               if (!noise_gate) audible = audible & mixer[5:3];
            end
            sum = env_accum + item.delta;
            if (sum > 64'hffff_ffff) sum = 64'hffff_ffff;
            env_accum = 32'(sum);
            env_limit = {15'd0, env_period, 1'b0};
            if (env_restart) begin
               env_step       = 4'd0;
               env_first_done = 1'b0;
               env_accum      = '0;
               env_restart    = 1'b0;
               env_direction  = 1'b1;
            end
            if (env_accum >= env_limit) begin
               env_accum = env_accum - env_limit;
               env_step  = env_step + 4'd1;
               if (env_step == 4'd0) begin
                  env_first_done = 1'b1;
                  env_direction  = ~env_direction;
               end
               env_level = envelope_level(env_shape, env_step, env_first_done, env_direction);
            end
            for (i = 0; i < 3; i++) begin
               if (!audible[i]) lvl[i] = '0;
               else if (volume[i][4]) lvl[i] = env_level;
               else lvl[i] = AMP_TABLE[volume[i][3:0]];
            end
            res.level_a = lvl[0];
            res.level_b = lvl[1];
            res.level_c = lvl[2];
         end
      endcase
      return res;
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_item(input mode_type mode, input logic [7:0] addr,
                             input logic [7:0] data, input logic [7:0] delta);
      req_payload_type item;
      item.mode     = mode;
      item.reg_addr = addr;
      item.data     = data;
      item.delta    = delta;
      pending_accesses.push_back(item);
      items_queued++;
   endtask

   task automatic queue_write(input logic [7:0] addr, input logic [7:0] data);
      queue_item(MODE_SELECT, addr, any_byte(), any_byte());
      queue_item(MODE_WRITE, any_byte(), data, any_byte());
   endtask

   task automatic queue_read(input logic [7:0] addr);
      queue_item(MODE_SELECT, addr, any_byte(), any_byte());
      queue_item(MODE_READ, any_byte(), any_byte(), any_byte());
   endtask

   task automatic queue_ticks(input int count, input int lo, input int hi);
      repeat (count) queue_item(MODE_TICK, any_byte(), any_byte(), 8'($urandom_range(lo, hi)));
   endtask

   // Mostly well-formed register traffic and tick runs, with small periods so that
   // tones, noise and envelope all move; the rest is arbitrary items.
   task automatic queue_random_traffic(input int count);
      int         goal;
      logic [7:0] addr;
      logic [7:0] value;
      goal = items_queued + count;
      while (items_queued < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               addr = 8'($urandom_range(0, 15));
               if ($urandom_range(0, 7) == 0) addr = any_byte();
               case (addr)
                  REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI, REG_ENV_HI:
                     value = ($urandom_range(0, 3) == 0) ? any_byte() : 8'h00;
                  REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO, REG_ENV_LO:
                     value = ($urandom_range(0, 3) == 0) ? any_byte() : 8'($urandom_range(0, 40));
                  default:
                     value = any_byte();
               endcase
               queue_write(addr, value);
            end
            3: queue_read(($urandom_range(0, 5) == 0) ? any_byte() : 8'($urandom_range(0, 15)));
            4, 5, 6: queue_ticks($urandom_range(1, 12), 0, ($urandom_range(0, 1) != 0) ? 255 : 15);
            7: begin
               queue_write(REG_ENV_SHAPE, any_byte());
               queue_ticks($urandom_range(4, 20), 0, 63);
            end
            default: queue_item(mode_type'($urandom_range(0, 3)), any_byte(), any_byte(), any_byte());
         endcase
      end
   endtask

   task automatic wait_for_drain();
      while (pending_accesses.size() != 0 || req_valid || expected_outputs.size() != 0)
         @(negedge clock);
   endtask

   // Sender: offers queued items and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_outputs.push_back(psg_next_output(req_payload));
            items_accepted++;
            if (req_payload.mode == MODE_TICK) ticks_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_accesses.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_accesses.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result against the oldest prediction and drives the stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               $error("result with no item outstanding: %h", rsp_payload);
               fail_count++;
            end else begin
               oldest_output = expected_outputs.pop_front();
               results_checked++;
               if (rsp_payload.read_data !== oldest_output.read_data) begin
                  $error("read_data: expected %0d, actual %0d",
                         oldest_output.read_data, rsp_payload.read_data);
                  fail_count++;
               end
               if (rsp_payload.level_a !== oldest_output.level_a) begin
                  $error("level_a: expected %0d, actual %0d",
                         oldest_output.level_a, rsp_payload.level_a);
                  fail_count++;
               end
               if (rsp_payload.level_b !== oldest_output.level_b) begin
                  $error("level_b: expected %0d, actual %0d",
                         oldest_output.level_b, rsp_payload.level_b);
                  fail_count++;
               end
               if (rsp_payload.level_c !== oldest_output.level_c) begin
                  $error("level_c: expected %0d, actual %0d",
                         oldest_output.level_c, rsp_payload.level_c);
                  fail_count++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (hold_served != hold_requests) begin
            rsp_stall   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
         end else begin
            rsp_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (!req_valid && pending_accesses.size() == 0 && expected_outputs.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("No item moved for %0d cycles; giving up.", WATCHDOG_LIMIT);
         $display("FAIL three_voice_psg_with_envelope_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      selected_reg   = '0;
      for (i = 0; i < 3; i++) begin
         tone_period[i] = '0;
         volume[i]      = '0;
         tone_count[i]  = 0;
         tone_bit[i]    = 1'b0;
      end
      noise_period   = '0;
      mixer          = 8'hff;
      env_period     = '0;
      env_shape      = '0;
      port_a         = 8'hff;
      port_b         = '0;
      env_restart    = 1'b0;
      noise_count    = 0;
      noise_gate     = 1'b0;
      lfsr           = LFSR_RESET;
      env_accum      = '0;
      env_step       = '0;
      env_first_done = 1'b0;
      env_direction  = 1'b1;
      env_level      = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register numbers beyond the map read as zero and swallow writes.
      queue_read(8'hff);
      queue_item(MODE_WRITE, 8'h00, 8'hff, 8'hff);
      queue_item(MODE_READ, 8'h00, 8'h00, 8'h00);
      queue_read(REG_PORT_A);
      queue_write(REG_PORT_B, 8'hff);
      queue_item(MODE_READ, 8'hff, 8'h00, 8'h00);
      queue_item(MODE_TICK, 8'h00, 8'h00, 8'h00);
      queue_item(MODE_TICK, 8'hff, 8'hff, 8'hff);
      queue_write(REG_MIXER, 8'h00);
      queue_write(REG_VOL_A, 8'hff);
      queue_write(REG_VOL_B, 8'h0f);
      queue_write(REG_ENV_SHAPE, 8'hff);
      queue_item(MODE_TICK, 8'h00, 8'h00, 8'hff);
      queue_item(MODE_TICK, 8'h00, 8'h00, 8'hff);
      queue_item(MODE_READ, 8'h00, 8'h00, 8'h00);

      // Tone A alone with a period below the step never toggles, so its count saturates;
      // zero steps afterwards let it toggle again.
      queue_write(REG_MIXER, 8'hfe);
      queue_write(REG_TONE_A_LO, 8'h02);
      queue_write(REG_TONE_A_HI, 8'h00);
      queue_write(REG_VOL_A, 8'h0f);
      queue_ticks(262, 255, 255);
      queue_ticks(3, 0, 0);

      // Envelope at its fastest runs past the first ramp: hold and alternation.
      queue_write(REG_MIXER, 8'hff);
      queue_write(REG_ENV_LO, 8'h00);
      queue_write(REG_ENV_HI, 8'h00);
      queue_write(REG_VOL_A, 8'h10);
      queue_write(REG_ENV_SHAPE, {4'd0, SHAPE_TRI_DOWN});
      queue_ticks(34, 0, 255);
      queue_write(REG_ENV_SHAPE, {4'd0, SHAPE_ATTACK_HOLD});
      queue_ticks(34, 0, 255);
      queue_random_traffic(RANDOM_PER_PHASE);
      wait_for_drain();

      send_idle_pct = 50;
      queue_random_traffic(RANDOM_PER_PHASE);
      wait_for_drain();

      send_idle_pct  = 0;
      recv_stall_pct = 50;
      queue_random_traffic(RANDOM_PER_PHASE);
      wait_for_drain();

      send_idle_pct  = 23;
      recv_stall_pct = 23;
      queue_random_traffic(RANDOM_PER_PHASE);
      wait_for_drain();

      // Results are held back for a long stretch while items keep coming.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      queue_random_traffic(60);
      wait_for_drain();

      repeat (10) @(posedge clock);
      $display("Checked %0d results for %0d items, %0d of them ticks,", results_checked,
               items_accepted, ticks_accepted);
      $display("under free flow, sender gaps, receiver stalls, both, and one long hold-off.");
      if (fail_count == 0) begin
         $display("PASS three_voice_psg_with_envelope_top");
      end else begin
         $display("FAIL three_voice_psg_with_envelope_top");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/psg_pkg.sv
hw/rtl/psg_regs.sv
hw/rtl/psg_tone.sv
hw/rtl/psg_env.sv
hw/rtl/three_voice_psg_with_envelope_top.sv
hw/rtl/psg_checker.sv
bench/three_voice_psg_with_envelope_top_test.sv
